>>> hdl/bakery_ticket_arbiter_top_macros.svh
// Assertion helpers used by the checker file.
`ifndef BAKERY_TICKET_ARBITER_TOP_MACROS_SVH
`define BAKERY_TICKET_ARBITER_TOP_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define BTA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BTA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/bta_pkg.sv
`default_nettype none
package bta_pkg;

   localparam int REQUESTERS  = 8;
   localparam int TICKET_BITS = 16;
   localparam int ID_BITS     = 3;
   localparam int COUNT_BITS  = 4;

   // Padded leaf count of the compare trees and their node count.
   localparam int TREE_LEAVES = 1 << $clog2(REQUESTERS);
   localparam int TREE_NODES  = 2 * TREE_LEAVES - 1;

   localparam logic [COUNT_BITS-1:0]  COUNT_RESET = COUNT_BITS'(REQUESTERS);
   localparam logic [TICKET_BITS-1:0] TICKET_TOP  = {TICKET_BITS{1'b1}};

   // Event codes.
   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [ID_BITS-1:0] id;
   } grant_type;

endpackage
`default_nettype wire

>>> hdl/bakery_ticket_arbiter_top.sv
// Bakery ticket arbiter: one event word in, one grant report word out.
// An accepted word waits in the input register until the report register is free or being
// drained, then its report is registered there and shown on rsp_*. Throughput: 1 word per
// cycle unless rsp_ready stalls; the ticket max tree, increment and grant min tree are
// combinational between the input and report registers. Reset (synchronous, active high)
// clears flags, tickets and both valid stages and sets the active count to eight.
`default_nettype none
module bakery_ticket_arbiter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [bta_pkg::COUNT_BITS-1:0]    csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [bta_pkg::ID_BITS-1:0]       req_requester_id,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bta_pkg::ID_BITS-1:0]       rsp_holder_id,
   output logic                              rsp_holder_valid,
   output logic [bta_pkg::TICKET_BITS-1:0]   rsp_ticket_given,
   output logic                              rsp_ticket_saturated,
   output logic                              rsp_bad_request
);
   import bta_pkg::*;

   logic [COUNT_BITS-1:0]  count_ff;
   logic                   in_valid_ff;
   logic                   in_op_ff;
   logic [ID_BITS-1:0]     in_id_ff;
   logic [REQUESTERS-1:0]  flags_ff;
   logic [TICKET_BITS-1:0] tickets_ff [REQUESTERS];
   logic                   out_valid_ff;
   logic [ID_BITS-1:0]     out_holder_id_ff;
   logic                   out_holder_valid_ff;
   logic [TICKET_BITS-1:0] out_given_ff;
   logic                   out_sat_ff;
   logic                   out_bad_ff;

   logic [REQUESTERS-1:0]  flags_in;
   logic [TICKET_BITS-1:0] tickets_in [REQUESTERS];
   logic [TICKET_BITS-1:0] given_in;
   logic                   sat_in;
   logic                   bad_in;
   logic                   out_valid_in;

   logic [COUNT_BITS-1:0]  eff_count;
   logic [REQUESTERS-1:0]  active;
   logic [TICKET_BITS-1:0] top_ticket;
   grant_type              grant;
   logic                   advance;

   // Move the held word on when the report register is free or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Clamp the active count and mark who takes part.
   always_comb begin
      if (count_ff == '0) begin
         eff_count = COUNT_BITS'(1);
      end else if (count_ff > COUNT_BITS'(REQUESTERS)) begin
         eff_count = COUNT_BITS'(REQUESTERS);
      end else begin
         eff_count = count_ff;
      end
      for (int k = 0; k < REQUESTERS; k++) begin
         active[k] = COUNT_BITS'(k) < eff_count;
      end
   end

   bta_ticket_max u_max (
      .tickets    (tickets_ff),
      .active     (active),
      .top_ticket (top_ticket)
   );

   // Apply the event to the flags and tickets.
   always_comb begin
      flags_in   = flags_ff;
      tickets_in = tickets_ff;
      given_in   = '0;
      sat_in     = 1'b0;
      bad_in     = COUNT_BITS'(in_id_ff) >= eff_count;
      if (!bad_in) begin
         if (in_op_ff == OP_REQUEST) begin
            sat_in               = top_ticket == TICKET_TOP;
            given_in             = sat_in ? TICKET_TOP : top_ticket + TICKET_BITS'(1);
            flags_in[in_id_ff]   = 1'b1;
            tickets_in[in_id_ff] = given_in;
         end else begin
            flags_in[in_id_ff] = 1'b0;
         end
      end
   end

   bta_grant_select u_grant (
      .tickets  (tickets_in),
      .eligible (flags_in & active),
      .grant    (grant)
   );

   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
         for (int k = 0; k < REQUESTERS; k++) begin
            tickets_ff[k] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            flags_ff   <= flags_in;
            tickets_ff <= tickets_in;
         end
      end
   end

   // Capture the event word and the report word.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_op_ff <= req_operation;
         in_id_ff <= req_requester_id;
      end
      if (advance) begin
         out_holder_id_ff    <= grant.id;
         out_holder_valid_ff <= grant.valid;
         out_given_ff        <= given_in;
         out_sat_ff          <= sat_in;
         out_bad_ff          <= bad_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_holder_id        = out_holder_id_ff;
   assign rsp_holder_valid     = out_holder_valid_ff;
   assign rsp_ticket_given     = out_given_ff;
   assign rsp_ticket_saturated = out_sat_ff;
   assign rsp_bad_request      = out_bad_ff;

endmodule
`default_nettype wire

>>> hdl/bta_ticket_max.sv
`default_nettype none
module bta_ticket_max (
   input  logic [bta_pkg::TICKET_BITS-1:0] tickets [bta_pkg::REQUESTERS],
   input  logic [bta_pkg::REQUESTERS-1:0]  active,
   output logic [bta_pkg::TICKET_BITS-1:0] top_ticket
);
   import bta_pkg::*;

   logic [TICKET_BITS-1:0] node_ticket [TREE_NODES];

   genvar k;
   genvar i;

   // Load leaves: inactive and padded slots count as zero.
   generate
      for (k = 0; k < TREE_LEAVES; k++) begin : g_leaf
         if (k < REQUESTERS) begin : g_real
            assign node_ticket[TREE_LEAVES-1+k] = active[k] ? tickets[k] : '0;
         end else begin : g_pad
            assign node_ticket[TREE_LEAVES-1+k] = '0;
         end
      end
   endgenerate

   // Reduce pairwise to the largest ticket.
   generate
      for (i = 0; i < TREE_LEAVES - 1; i++) begin : g_node
         assign node_ticket[i] = (node_ticket[2*i+1] >= node_ticket[2*i+2]) ?
                                 node_ticket[2*i+1] : node_ticket[2*i+2];
      end
   endgenerate

   assign top_ticket = node_ticket[0];

endmodule
`default_nettype wire

>>> hdl/bta_grant_select.sv
`default_nettype none
module bta_grant_select (
   input  logic [bta_pkg::TICKET_BITS-1:0] tickets [bta_pkg::REQUESTERS],
   input  logic [bta_pkg::REQUESTERS-1:0]  eligible,
   output bta_pkg::grant_type              grant
);
   import bta_pkg::*;

   logic [TREE_NODES-1:0]  node_valid;
   logic [TICKET_BITS-1:0] node_ticket [TREE_NODES];
   logic [ID_BITS-1:0]     node_id [TREE_NODES];

   genvar k;
   genvar i;

   // Load leaves with the flagged requesters.
   generate
      for (k = 0; k < TREE_LEAVES; k++) begin : g_leaf
         if (k < REQUESTERS) begin : g_real
            assign node_valid[TREE_LEAVES-1+k]  = eligible[k];
            assign node_ticket[TREE_LEAVES-1+k] = tickets[k];
         end else begin : g_pad
            assign node_valid[TREE_LEAVES-1+k]  = 1'b0;
            assign node_ticket[TREE_LEAVES-1+k] = '0;
         end
         assign node_id[TREE_LEAVES-1+k] = ID_BITS'(k);
      end
   endgenerate

   // Keep the smaller ticket; the left side holds lower ids and wins a tie.
   generate
      for (i = 0; i < TREE_LEAVES - 1; i++) begin : g_node
         logic take_left;
         assign take_left = node_valid[2*i+1] &&
                            (!node_valid[2*i+2] ||
                             (node_ticket[2*i+1] <= node_ticket[2*i+2]));
         assign node_valid[i]  = node_valid[2*i+1] || node_valid[2*i+2];
         assign node_ticket[i] = take_left ? node_ticket[2*i+1] : node_ticket[2*i+2];
         assign node_id[i]     = take_left ? node_id[2*i+1] : node_id[2*i+2];
      end
   endgenerate

   // Report id zero when nobody is waiting.
   assign grant.valid = node_valid[0];
   assign grant.id    = node_valid[0] ? node_id[0] : '0;

endmodule
`default_nettype wire

>>> hdl/bta_checker.sv
`default_nettype none
`include "bakery_ticket_arbiter_top_macros.svh"
module bta_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              rsp_valid,
   input  wire                              rsp_ready,
   input  wire [bta_pkg::ID_BITS-1:0]       rsp_holder_id,
   input  wire                              rsp_holder_valid,
   input  wire [bta_pkg::TICKET_BITS-1:0]   rsp_ticket_given,
   input  wire                              rsp_ticket_saturated,
   input  wire                              rsp_bad_request
);
   import bta_pkg::*;

   logic [ID_BITS+TICKET_BITS+2:0] rsp_word;

   // Gather the whole report word.
   assign rsp_word = {rsp_holder_id, rsp_holder_valid, rsp_ticket_given,
                      rsp_ticket_saturated, rsp_bad_request};

   // Drop any pending report on reset.
   `BTA_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "report valid after reset")

   // Hold a stalled report word.
   `BTA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word),
               "stalled report changed")

   // Report id zero when nobody holds the lock.
   `BTA_ASSERT(a_no_holder, rsp_valid && !rsp_holder_valid |-> rsp_holder_id == '0,
               "holder id set without holder")

   // Saturate only at the top ticket.
   `BTA_ASSERT(a_sat_top, rsp_valid && rsp_ticket_saturated |-> rsp_ticket_given == TICKET_TOP,
               "saturated ticket below top")

   // Give no ticket to a rejected requester.
   `BTA_ASSERT(a_bad_quiet,
               rsp_valid && rsp_bad_request |-> rsp_ticket_given == '0 && !rsp_ticket_saturated,
               "ticket on rejected word")

endmodule

bind bakery_ticket_arbiter_top bta_checker u_bta_checker (.*);
`default_nettype wire

>>> verif/bakery_ticket_arbiter_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module bakery_ticket_arbiter_top_tb;
   import bta_pkg::*;

   // One lock word as the sender holds it.
   typedef struct packed {
      logic               operation;
      logic [ID_BITS-1:0] requester_id;
   } lock_word_type;

   // One grant report word as the block returns it.
   typedef struct packed {
      logic [ID_BITS-1:0]     holder_id;
      logic                   holder_valid;
      logic [TICKET_BITS-1:0] ticket_given;
      logic                   ticket_saturated;
      logic                   bad_request;
   } grant_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [COUNT_BITS-1:0]  csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_operation = OP_REQUEST;
   logic [ID_BITS-1:0]     req_requester_id = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [ID_BITS-1:0]     rsp_holder_id;
   logic                   rsp_holder_valid;
   logic [TICKET_BITS-1:0] rsp_ticket_given;
   logic                   rsp_ticket_saturated;
   logic                   rsp_bad_request;

   bakery_ticket_arbiter_top dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_requester_id     (req_requester_id),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_holder_id        (rsp_holder_id),
      .rsp_holder_valid     (rsp_holder_valid),
      .rsp_ticket_given     (rsp_ticket_given),
      .rsp_ticket_saturated (rsp_ticket_saturated),
      .rsp_bad_request      (rsp_bad_request)
   );

   // Shadow copy of the lock state and the active count register.
   logic                   interest_shadow [REQUESTERS];
   logic [TICKET_BITS-1:0] ticket_shadow [REQUESTERS];
   logic [COUNT_BITS-1:0]  active_count_shadow = COUNT_RESET;

   lock_word_type    pending_words [$];
   grant_report_type grant_reports_due [$];
   int               words_in_flight = 0;
   int               fault_count = 0;
   int               mismatch_count = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_idle_pct = 0;

   initial begin
      for (int k = 0; k < REQUESTERS; k++) begin
         interest_shadow[k] = 1'b0;
         ticket_shadow[k]   = '0;
      end
   end

   // Apply one lock word to the shadow state and return the report it causes.
   function automatic grant_report_type predict_grant(logic op, logic [ID_BITS-1:0] id);
      grant_report_type       report;
      int unsigned            span;
      logic [TICKET_BITS-1:0] top;
      logic [TICKET_BITS-1:0] best;
      report = '0;
      best   = '0;
      top    = '0;
      if (active_count_shadow == 0) span = 1;
      else if (active_count_shadow > REQUESTERS) span = REQUESTERS;
      else span = active_count_shadow;
      if (id >= span) begin
         report.bad_request = 1'b1;
      end else if (op == OP_REQUEST) begin
         for (int k = 0; k < span; k++) begin
            if (ticket_shadow[k] > top) top = ticket_shadow[k];
         end
         if (top == TICKET_TOP) begin
            report.ticket_given     = TICKET_TOP;
            report.ticket_saturated = 1'b1;
         end else begin
            report.ticket_given = top + 1'b1;
         end
         interest_shadow[id] = 1'b1;
         ticket_shadow[id]   = report.ticket_given;
      end else begin
         interest_shadow[id] = 1'b0;
      end
      // Pick the smallest flagged ticket, lower id on a tie.
      for (int k = 0; k < span; k++) begin
         if (interest_shadow[k] && (!report.holder_valid || ticket_shadow[k] < best)) begin
            report.holder_valid = 1'b1;
            report.holder_id    = k[ID_BITS-1:0];
            best                = ticket_shadow[k];
         end
      end
      return report;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // Feed the request channel from the pending queue.
   always @(posedge clock) begin : drive_words
      lock_word_type word;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            word = pending_words.pop_front();
            req_valid        <= 1'b1;
            req_operation    <= word.operation;
            req_requester_id <= word.requester_id;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the report channel at random.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Check each report word, then predict for each accepted lock word.
   always @(posedge clock) begin : watch_ports
      grant_report_type seen;
      grant_report_type due;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen.holder_id        = rsp_holder_id;
            seen.holder_valid     = rsp_holder_valid;
            seen.ticket_given     = rsp_ticket_given;
            seen.ticket_saturated = rsp_ticket_saturated;
            seen.bad_request      = rsp_bad_request;
            words_in_flight--;
            if (grant_reports_due.size() == 0) begin
               fault_count++;
               if (mismatch_count < 10)
                  $display("unexpected report: holder %0d/%0b ticket %0d sat %0b bad %0b",
                           seen.holder_id, seen.holder_valid, seen.ticket_given,
                           seen.ticket_saturated, seen.bad_request);
               mismatch_count++;
            end else begin
               due = grant_reports_due.pop_front();
               if (seen.holder_id !== due.holder_id || seen.holder_valid !== due.holder_valid
                   || seen.ticket_given !== due.ticket_given
                   || seen.ticket_saturated !== due.ticket_saturated
                   || seen.bad_request !== due.bad_request) begin
                  fault_count++;
                  if (mismatch_count < 10) begin
                     $display("report mismatch: expected holder %0d/%0b ticket %0d sat %0b bad %0b",
                              due.holder_id, due.holder_valid, due.ticket_given,
                              due.ticket_saturated, due.bad_request);
                     $display("                 got holder %0d/%0b ticket %0d sat %0b bad %0b",
                              seen.holder_id, seen.holder_valid, seen.ticket_given,
                              seen.ticket_saturated, seen.bad_request);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            grant_reports_due.push_back(predict_grant(req_operation, req_requester_id));
      end
   end

   task automatic push_word(logic op, logic [ID_BITS-1:0] id);
      lock_word_type word;
      word.operation    = op;
      word.requester_id = id;
      words_in_flight++;
      pending_words.push_back(word);
   endtask

   // Hold until every word has reported, plus a latency margin.
   task automatic wait_drained();
      while (words_in_flight > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_active_count(logic [COUNT_BITS-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_count_shadow = value;
      @(posedge clock);
   endtask

   // Mostly in-range ids, with some out-of-range noise.
   task automatic run_random(logic [COUNT_BITS-1:0] value, int words);
      int unsigned span;
      logic        op;
      logic [ID_BITS-1:0] id;
      write_active_count(value);
      if (value == 0) span = 1;
      else if (value > REQUESTERS) span = REQUESTERS;
      else span = value;
      for (int n = 0; n < words; n++) begin
         op = ($urandom_range(99) < 55) ? OP_REQUEST : OP_RELEASE;
         if ($urandom_range(99) < 85) id = ID_BITS'($urandom_range(span - 1, 0));
         else id = ID_BITS'($urandom_range(REQUESTERS - 1, 0));
         push_word(op, id);
      end
   endtask

   task automatic run_phase();
      run_random(4'd8, 110);
      run_random(4'd5, 110);
      run_random(4'd1, 100);
      run_random(4'd12, 110);
      run_random(4'd3, 110);
      run_random(COUNT_BITS'($urandom_range(15, 0)), 110);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 9;
      recv_idle_pct = 86;

      // Directed: empty release, top id, repeat request, idle release.
      push_word(OP_RELEASE, 3'd0);
      push_word(OP_REQUEST, 3'd7);
      push_word(OP_REQUEST, 3'd0);
      push_word(OP_REQUEST, 3'd3);
      push_word(OP_REQUEST, 3'd3);
      push_word(OP_RELEASE, 3'd7);
      push_word(OP_RELEASE, 3'd7);
      push_word(OP_RELEASE, 3'd0);
      // Zero count acts as one.
      write_active_count(4'd0);
      push_word(OP_REQUEST, 3'd1);
      push_word(OP_REQUEST, 3'd0);
      push_word(OP_RELEASE, 3'd7);
      // Top register value acts as the full set.
      write_active_count(4'd15);
      push_word(OP_REQUEST, 3'd5);
      push_word(OP_REQUEST, 3'd6);
      // Shrunk count keeps the upper flags but ignores them.
      write_active_count(4'd3);
      push_word(OP_REQUEST, 3'd5);
      push_word(OP_RELEASE, 3'd2);
      push_word(OP_REQUEST, 3'd2);
      push_word(OP_RELEASE, 3'd0);
      push_word(OP_RELEASE, 3'd2);
      // Grow back past the full set.
      write_active_count(4'd9);
      push_word(OP_RELEASE, 3'd3);
      push_word(OP_RELEASE, 3'd5);
      push_word(OP_RELEASE, 3'd0);
      push_word(OP_REQUEST, 3'd4);

      run_phase();

      wait_drained();
      send_idle_pct = 86;
      recv_idle_pct = 9;
      run_phase();

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase();

      wait_drained();
      repeat (8) @(posedge clock);
      if (fault_count == 0 && grant_reports_due.size() == 0) begin
         $display("bakery_ticket_arbiter_top_tb passed");
      end else begin
         $display("bakery_ticket_arbiter_top_tb failed");
      end
      $finish;
   end

   // Drop the run if the block stops answering.
   initial begin
      #5ms;
      $display("bakery_ticket_arbiter_top_tb failed");
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
+incdir+hdl
hdl/bta_pkg.sv
hdl/bta_ticket_max.sv
hdl/bta_grant_select.sv
hdl/bakery_ticket_arbiter_top.sv
hdl/bta_checker.sv
verif/bakery_ticket_arbiter_top_tb.sv
